[rtl/fca_pkg.sv]
package fca_pkg;

    localparam int unsigned ENTRY_W = 12;
    localparam int unsigned COUNT_W = 13;

    localparam logic [ENTRY_W-1:0] ENTRY_END    = 12'hFFF;
    localparam logic [COUNT_W-1:0] FIRST_USABLE = 13'd2;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_LINK  = 2'd2,
        MODE_BAD   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_RANGE   = 2'd2,
        STAT_BROKEN  = 2'd3
    } status_t;

    // value written into the table entry at the current index
    typedef enum logic [1:0] {
        WSEL_END  = 2'd0,
        WSEL_ZERO = 2'd1,
        WSEL_NEXT = 2'd2
    } wsel_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_LINK_RD,
        ST_LINK_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic    load;
        logic    clr;
        logic    rd;
        logic    wr;
        wsel_t   wsel;
        logic    cur_inc;
        logic    cur_link;
        logic    freed_inc;
        logic    set_alloc;
        logic    set_status;
        status_t status;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic cur_end;
        logic cur_range_bad;
        logic cur_past_bound;
        logic rdata_zero;
        logic out_free;
    } flags_t;

endpackage

[rtl/fca_ctrl.sv]
module fca_ctrl
    import fca_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  mode_t  in_mode,
    output logic   in_ready,
    input  flags_t flags,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (flags.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_mode)
                        MODE_ALLOC: state_next = ST_ALLOC_RD;
                        MODE_FREE:  state_next = ST_FREE_RD;
                        MODE_LINK:  state_next = ST_LINK_RD;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_ALLOC_RD:
            begin
                state_next = flags.cur_past_bound ? ST_DONE : ST_ALLOC_CHK;
            end
            ST_ALLOC_CHK:
            begin
                state_next = flags.rdata_zero ? ST_DONE : ST_ALLOC_RD;
            end
            ST_FREE_RD:
            begin
                if (flags.cur_end || flags.cur_range_bad)
                    state_next = ST_DONE;
                else
                    state_next = ST_FREE_CHK;
            end
            ST_FREE_CHK:
            begin
                state_next = flags.rdata_zero ? ST_DONE : ST_FREE_RD;
            end
            ST_LINK_RD:
            begin
                state_next = flags.cur_range_bad ? ST_DONE : ST_LINK_WR;
            end
            ST_LINK_WR:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (flags.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_ALLOC_RD:
            begin
                if (flags.cur_past_bound)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_NO_FREE;
                end
                else
                begin
                    cmd.rd = 1'b1;
                end
            end
            ST_ALLOC_CHK:
            begin
                if (flags.rdata_zero)
                begin
                    cmd.wr        = 1'b1;
                    cmd.wsel      = WSEL_END;
                    cmd.set_alloc = 1'b1;
                end
                else
                begin
                    cmd.cur_inc = 1'b1;
                end
            end
            ST_FREE_RD:
            begin
                if (!flags.cur_end)
                begin
                    if (flags.cur_range_bad)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = STAT_RANGE;
                    end
                    else
                    begin
                        cmd.rd = 1'b1;
                    end
                end
            end
            ST_FREE_CHK:
            begin
                if (flags.rdata_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_BROKEN;
                end
                else
                begin
                    cmd.wr        = 1'b1;
                    cmd.wsel      = WSEL_ZERO;
                    cmd.freed_inc = 1'b1;
                    cmd.cur_link  = 1'b1;
                end
            end
            ST_LINK_RD:
            begin
                if (flags.cur_range_bad)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_RANGE;
                end
                else
                begin
                    cmd.rd = 1'b1;
                end
            end
            ST_LINK_WR:
            begin
                cmd.wr   = 1'b1;
                cmd.wsel = WSEL_NEXT;
            end
            ST_DONE:
            begin
                cmd.out_load = flags.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/fca_dp.sv]
module fca_dp
    import fca_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,
    input  mode_t               in_mode,
    input  logic [ENTRY_W-1:0]  in_block,
    input  logic [ENTRY_W-1:0]  in_succ,
    input  cmd_t                cmd,
    output flags_t              flags,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [ENTRY_W-1:0]  out_allocated_index,
    output status_t             out_status,
    output logic [COUNT_W-1:0]  out_freed_count,
    output logic [COUNT_W-1:0]  out_free_count
);

    localparam int unsigned AW = $clog2(NUM_BLOCKS);
    localparam logic [COUNT_W-1:0] NB       = COUNT_W'(NUM_BLOCKS);
    localparam logic [AW-1:0]      CLR_LAST = AW'(NUM_BLOCKS - 1);

    logic [ENTRY_W-1:0] mem [NUM_BLOCKS];
    logic [ENTRY_W-1:0] rdata_reg;

    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] hint_reg;
    logic [COUNT_W-1:0] hint_next;
    logic [AW-1:0]      clr_cnt_reg;

    logic [COUNT_W-1:0] cur_reg;
    logic [ENTRY_W-1:0] next_reg;
    logic [ENTRY_W-1:0] alloc_reg;
    status_t            status_reg;
    logic [COUNT_W-1:0] freed_reg;

    logic               out_valid_reg;
    logic [ENTRY_W-1:0] out_alloc_reg;
    status_t            out_status_reg;
    logic [COUNT_W-1:0] out_freed_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [COUNT_W-1:0] bound;
    logic [AW-1:0]      cur_addr;
    logic [AW-1:0]      waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               we;
    logic               old_zero;
    logic               new_zero;

    assign bound    = (total_reg > NB) ? NB : total_reg;
    assign cur_addr = cur_reg[AW-1:0];

    always_comb
    begin
        case (cmd.wsel)
            WSEL_END:  wdata = ENTRY_END;
            WSEL_NEXT: wdata = next_reg;
            default:   wdata = '0;
        endcase
        if (cmd.clr)
            wdata = '0;
    end

    assign we    = cmd.wr || cmd.clr;
    assign waddr = cmd.clr ? clr_cnt_reg : cur_addr;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (cmd.rd)
            rdata_reg <= mem[cur_addr];
    end

    assign old_zero = (rdata_reg == '0);
    assign new_zero = (wdata == '0);

    // free count follows every table write outside the clearing pass; saturates at both ends
    always_comb
    begin
        count_next = count_reg;
        if (cmd.wr)
        begin
            if (old_zero && !new_zero && count_reg != '0)
                count_next = count_reg - 1'b1;
            else if (!old_zero && new_zero && count_reg < NB)
                count_next = count_reg + 1'b1;
        end
    end

    // every entry in [2, hint) is known to be in use
    always_comb
    begin
        hint_next = hint_reg;
        if (cmd.wr)
        begin
            if (cmd.wsel == WSEL_END)
                hint_next = cur_reg + 1'b1;
            else if (new_zero && cur_reg < hint_reg)
                hint_next = cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= 13'd4096;
            count_reg   <= COUNT_W'(NUM_BLOCKS - 2);
            hint_reg    <= FIRST_USABLE;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                total_reg <= cfg_wdata;
            count_reg <= count_next;
            hint_reg  <= hint_next;
            if (cmd.clr)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg    <= (in_mode == MODE_ALLOC) ? hint_reg : {1'b0, in_block};
            next_reg   <= in_succ;
            alloc_reg  <= '0;
            freed_reg  <= '0;
            status_reg <= (in_mode == MODE_BAD) ? STAT_RANGE : STAT_OK;
        end
        else
        begin
            if (cmd.cur_inc)
                cur_reg <= cur_reg + 1'b1;
            else if (cmd.cur_link)
                cur_reg <= {1'b0, rdata_reg};
            if (cmd.set_alloc)
                alloc_reg <= cur_reg[ENTRY_W-1:0];
            if (cmd.freed_inc)
                freed_reg <= freed_reg + 1'b1;
            if (cmd.set_status)
                status_reg <= cmd.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_alloc_reg  <= alloc_reg;
            out_status_reg <= status_reg;
            out_freed_reg  <= freed_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign flags.clr_done       = (clr_cnt_reg == CLR_LAST);
    assign flags.cur_end        = (cur_reg == {1'b0, ENTRY_END});
    assign flags.cur_range_bad  = (cur_reg < FIRST_USABLE) || (cur_reg >= bound);
    assign flags.cur_past_bound = (cur_reg >= bound);
    assign flags.rdata_zero     = old_zero;
    assign flags.out_free       = !out_valid_reg || out_ready;

    assign out_valid           = out_valid_reg;
    assign out_allocated_index = out_alloc_reg;
    assign out_status          = out_status_reg;
    assign out_freed_count     = out_freed_reg;
    assign out_free_count      = out_count_reg;

endmodule

[rtl/fat_cluster_allocator.sv]
// channel | dir | handshake         | payload
// cfg     | in  | cfg_we            | cfg_wdata: block limit
// s       | in  | s_tvalid/s_tready | tdata: block, successor; tuser: mode
// m       | out | m_tvalid/m_tready | tdata: allocated_index, freed_count, free_count;
//         |     |                   | tuser: status
//
// One request at a time; table is a single-port RAM, one access per step.
// Allocate probes entries upward from the hint, reading then checking each one; free
// walks the chain, reading each link then clearing it; link reads the entry, then writes
// the successor (skipped when out of range); an unknown mode goes straight to the result.
// After reset a clearing pass zeroes every table entry before s_tready rises.
// A result waits in the output register while the next request runs; that one stalls
// in its last cycle until the register is free.
module fat_cluster_allocator
    import fca_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,  // block limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [11:0] block, [23:12] successor
    input  logic [1:0]  s_tuser,    // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [11:0] allocated_index, [24:12] freed_count,
                                    // [37:25] free_count, [39:38] zero
    output logic [1:0]  m_tuser     // [1:0] status
);

    cmd_t               cmd;
    flags_t             flags;
    mode_t              in_mode;
    status_t            out_status;
    logic [ENTRY_W-1:0] out_alloc;
    logic [COUNT_W-1:0] out_freed;
    logic [COUNT_W-1:0] out_count;

    assign in_mode = mode_t'(s_tuser);

    fca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (in_mode),
        .in_ready (s_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    fca_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .in_mode             (in_mode),
        .in_block            (s_tdata[11:0]),
        .in_succ             (s_tdata[23:12]),
        .cmd                 (cmd),
        .flags               (flags),
        .out_ready           (m_tready),
        .out_valid           (m_tvalid),
        .out_allocated_index (out_alloc),
        .out_status          (out_status),
        .out_freed_count     (out_freed),
        .out_free_count      (out_count)
    );

    assign m_tdata = {2'b00, out_count, out_freed, out_alloc};
    assign m_tuser = out_status;

endmodule

[rtl/fca_checker.sv]
module fca_checker
    import fca_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS = 4096
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // index is reported only on success
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_OK) |-> m_tdata[11:0] == '0)
        else $error("allocated index on failed request");

    // exhausted table comes only from an allocate, which frees nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_NO_FREE) |-> m_tdata[24:12] == '0)
        else $error("entries freed on allocate");

    // count never exceeds table size
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[37:25] <= 13'(NUM_BLOCKS))
        else $error("free count above table size");

    // a taken request keeps the block busy in the cycle after it is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken on consecutive cycles");

endmodule

bind fat_cluster_allocator fca_checker #(
    .NUM_BLOCKS (NUM_BLOCKS)
) u_fca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/sv/fca_tb_pkg.sv]
`timescale 1ns / 1ps
package fca_tb_pkg;
    import fca_pkg::*;

    localparam int unsigned TABLE_SIZE = 4096;

    typedef struct {
        logic [11:0] alloc_idx;
        status_t     status;
        logic [12:0] freed;
        logic [12:0] free_left;
    } fat_result_t;

    class fat_scoreboard;
        logic [11:0] fat_copy [TABLE_SIZE];
        logic [12:0] free_left;
        logic [12:0] blk_limit;
        fat_result_t expected_q [$];
        // recently allocated entries, used to build well-formed chains
        logic [11:0] owned [$];
        int unsigned mismatches;

        function new();
            foreach (fat_copy[i])
                fat_copy[i] = '0;
            free_left  = 13'(TABLE_SIZE - 2);
            blk_limit  = 13'd4096;
            mismatches = 0;
        endfunction

        function int unsigned bound();
            return (blk_limit > TABLE_SIZE) ? TABLE_SIZE : blk_limit;
        endfunction

        function void set_total(logic [12:0] v);
            logic [11:0] keep [$];
            blk_limit = v;
            foreach (owned[i])
                if (owned[i] < bound())
                    keep.push_back(owned[i]);
            owned = keep;
        endfunction

        function logic [11:0] pick_owned();
            return owned[$urandom_range(0, owned.size() - 1)];
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // apply one accepted request to the table copy, queue what it returns
        function void note_request(mode_t mode, logic [11:0] blk, logic [11:0] nxt);
            fat_result_t r;
            int unsigned bnd;
            int unsigned cur;
            logic [11:0] link;
            logic [11:0] old;
            bnd         = bound();
            r.alloc_idx = '0;
            r.status    = STAT_OK;
            r.freed     = '0;
            case (mode)
                MODE_ALLOC:
                begin
                    r.status = STAT_NO_FREE;
                    for (int unsigned i = FIRST_USABLE; i < bnd; i++)
                    begin
                        if (fat_copy[i] == '0)
                        begin
                            fat_copy[i] = ENTRY_END;
                            if (free_left != 0)
                                free_left--;
                            r.alloc_idx = 12'(i);
                            r.status    = STAT_OK;
                            owned.push_back(12'(i));
                            if (owned.size() > 48)
                                void'(owned.pop_front());
                            break;
                        end
                    end
                end
                MODE_FREE:
                begin
                    cur = blk;
                    while (cur != ENTRY_END)
                    begin
                        if (cur < FIRST_USABLE || cur >= bnd)
                        begin
                            r.status = STAT_RANGE;
                            break;
                        end
                        link = fat_copy[cur];
                        if (link == '0)
                        begin
                            r.status = STAT_BROKEN;
                            break;
                        end
                        fat_copy[cur] = '0;
                        if (free_left < TABLE_SIZE)
                            free_left++;
                        r.freed++;
                        cur = link;
                    end
                end
                MODE_LINK:
                begin
                    if (blk < FIRST_USABLE || blk >= bnd)
                        r.status = STAT_RANGE;
                    else
                    begin
                        old           = fat_copy[blk];
                        fat_copy[blk] = nxt;
                        if (old == '0 && nxt != '0)
                        begin
                            if (free_left != 0)
                                free_left--;
                        end
                        else if (old != '0 && nxt == '0)
                        begin
                            if (free_left < TABLE_SIZE)
                                free_left++;
                        end
                    end
                end
                default:
                    r.status = STAT_RANGE;
            endcase
            r.free_left = free_left;
            expected_q.push_back(r);
        endfunction

        function void compare(string name, logic [12:0] exp, logic [12:0] got);
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in %s: expected %0d, got %0d", name, exp, got);
            end
        endfunction

        function void check_result(logic [39:0] data, logic [1:0] user);
            fat_result_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no request pending: tdata %h tuser %h", data, user);
                return;
            end
            e = expected_q.pop_front();
            compare("allocated_index", e.alloc_idx, data[11:0]);
            compare("status", e.status, user);
            compare("freed_count", e.freed, data[24:12]);
            compare("free_count", e.free_left, data[37:25]);
            compare("tdata padding", '0, data[39:38]);
        endfunction
    endclass

endpackage

[tb/sv/tb_fat_cluster_allocator.sv]
`timescale 1ns / 1ps
module tb_fat_cluster_allocator;
    import fca_pkg::*;
    import fca_tb_pkg::*;

    localparam int unsigned NUM_BLOCKS   = 4096;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_ITEMS  = 72;
    localparam longint unsigned CYCLE_LIMIT = 25_000_000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [12:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [11:0] block, [23:12] successor
    logic [1:0]  s_tuser;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [11:0] allocated_index, [24:12] freed_count,
                            // [37:25] free_count, [39:38] zero
    logic [1:0]  m_tuser;   // [1:0] status

    fat_scoreboard sb;
    bit hold_req;
    bit quiet_s;
    bit quiet_m;
    longint unsigned cycles;

    fat_cluster_allocator #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stalls per result, plus one long hold-off on request
    initial
    begin
        int unsigned stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata, m_tuser);
                stall = quiet_m ? 0 : $urandom_range(0, 15);
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_req(mode_t mode, logic [11:0] blk, logic [11:0] nxt);
        int unsigned gap;
        gap = quiet_s ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {nxt, blk};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(mode, blk, nxt);
    endtask

    task automatic write_cfg(logic [12:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_total(v);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // mostly well-formed chain work on owned entries, some noise
    task automatic random_req();
        int unsigned r;
        logic [11:0] a;
        logic [11:0] b;
        mode_t m;
        r = $urandom_range(0, 99);
        a = 12'($urandom);
        b = 12'($urandom);
        if (sb.owned.size() == 0 && r >= 35 && r < 80)
            r = 0;
        if (r < 35)
            m = MODE_ALLOC;
        else if (r < 55)
        begin
            m = MODE_LINK;
            a = sb.pick_owned();
            b = ($urandom_range(0, 2) == 0) ? ENTRY_END : sb.pick_owned();
        end
        else if (r < 80)
        begin
            m = MODE_FREE;
            a = sb.pick_owned();
        end
        else if (r < 90)
        begin
            m = MODE_LINK;
            if (r < 83)
                b = '0;
        end
        else if (r < 96)
            m = MODE_FREE;
        else
            m = MODE_BAD;
        send_req(m, a, b);
    endtask

    initial
    begin
        logic [12:0] v;
        sb        = new();
        hold_req  = 1'b0;
        quiet_s   = 1'b0;
        quiet_m   = 1'b0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_ALLOC;
        m_tready  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_cfg(13'd4096);
        send_req(MODE_ALLOC, 12'h000, 12'h000);
        send_req(MODE_ALLOC, 12'hFFF, 12'hFFF);
        send_req(MODE_ALLOC, 12'h000, 12'h000);
        send_req(MODE_LINK, 12'd2, 12'd3);
        send_req(MODE_LINK, 12'd3, 12'd4);
        send_req(MODE_FREE, 12'd2, 12'h000);      // three-entry chain
        send_req(MODE_FREE, ENTRY_END, 12'h000);  // empty chain
        send_req(MODE_FREE, 12'd0, 12'h000);      // reserved entries
        send_req(MODE_FREE, 12'd1, 12'h000);
        send_req(MODE_FREE, 12'd4095, 12'h000);   // 4095 equals the end marker, so an empty chain
        send_req(MODE_LINK, 12'd0, ENTRY_END);
        send_req(MODE_LINK, 12'd1, 12'd5);
        send_req(MODE_LINK, 12'd4095, ENTRY_END);
        send_req(MODE_LINK, 12'd4095, 12'd0);
        send_req(MODE_LINK, 12'd4095, 12'd0);
        send_req(MODE_BAD, 12'hFFF, 12'hFFF);
        send_req(MODE_ALLOC, 12'h000, 12'h000);
        send_req(MODE_ALLOC, 12'h000, 12'h000);
        send_req(MODE_LINK, 12'd2, 12'd3);
        send_req(MODE_LINK, 12'd3, 12'd2);        // loop
        send_req(MODE_FREE, 12'd2, 12'h000);
        drain();

        write_cfg(13'd3);
        send_req(MODE_ALLOC, 12'h000, 12'h000);
        send_req(MODE_ALLOC, 12'h000, 12'h000);   // nothing free
        send_req(MODE_LINK, 12'd2, 12'hFFE);
        send_req(MODE_FREE, 12'd2, 12'h000);      // walks past the bound
        send_req(MODE_LINK, 12'd3, 12'd1);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0:       v = 13'd3;
                1:       v = 13'd8;
                2:       v = 13'd64;
                3:       v = 13'd4096;
                4:       v = 13'd20;
                5:       v = 13'd8191;
                6:       v = 13'd0;
                7:       v = 13'd150;
                8:       v = 13'd4096;
                9:       v = 13'd5;
                10:      v = 13'd2;
                default: v = 13'd4096;
            endcase
            write_cfg(v);
            quiet_s = (p % 4 == 1);
            quiet_m = (p % 4 == 2);
            if (p == 2)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 5 && n == PHASE_ITEMS / 2)
                    drain();
                random_req();
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
